// ===== sv/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned RESULT_FIFO_DEPTH = 4;

  localparam logic        KIND_DATA = 1'b0;
  localparam logic        KIND_END  = 1'b1;

  localparam logic        RESULT_UNIT   = 1'b0;
  localparam logic        RESULT_REPORT = 1'b1;

  localparam logic        STATUS_OK    = 1'b0;
  localparam logic        STATUS_ERROR = 1'b1;

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
  localparam logic [20:0] MAX_POINT      = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST     = 21'h00D800;
  localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
  localparam logic [20:0] BMP_LAST       = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] code_unit;
    logic        status;
    logic [15:0] unit_count;
    logic        last;
  } result_t;

  // What one accepted item pushes into the result queue.
  typedef struct packed {
    logic    push_first;
    logic    push_second;
    result_t first;
    result_t second;
  } dec_out_t;

endpackage

// ===== sv/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// u8u16_decode
// Decoder state and the single-pass logic that turns one transfer into zero,
// one or two results.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                kind,
  input  logic [7:0]          text_byte,
  input  logic [15:0]         capacity,
  output u8u16_pkg::dec_out_t dec
);

  logic [20:0] partial_point, partial_point_next;
  logic [1:0]  bytes_due, bytes_due_next;
  logic [15:0] units_emitted, units_emitted_next;
  logic        failed, failed_next;

  logic [20:0] cont_point;
  logic [20:0] cp;
  logic        finish;
  logic [19:0] supp_offset;
  logic        bad_end;

  assign cont_point  = {partial_point[14:0], text_byte[5:0]};
  assign supp_offset = 20'(cp - u8u16_pkg::SUPP_BASE);
  assign bad_end     = failed || (bytes_due != 2'd0);

  always_comb begin
    partial_point_next = partial_point;
    bytes_due_next     = bytes_due;
    units_emitted_next = units_emitted;
    failed_next        = failed;
    finish             = 1'b0;
    cp                 = {13'd0, text_byte};
    dec                = '0;

    if (kind == u8u16_pkg::KIND_END) begin
      dec.push_first             = 1'b1;
      dec.first.result_kind      = u8u16_pkg::RESULT_REPORT;
      dec.first.status           = bad_end ? u8u16_pkg::STATUS_ERROR : u8u16_pkg::STATUS_OK;
      dec.first.unit_count       = bad_end ? 16'd0 : units_emitted;
      dec.first.last             = 1'b1;
      partial_point_next         = '0;
      bytes_due_next             = '0;
      units_emitted_next         = '0;
      failed_next                = 1'b0;
    end else if (!failed) begin
      if (bytes_due == 2'd0) begin
        if (!text_byte[7]) begin
          finish = 1'b1;
        end else if (text_byte[7:5] == 3'b110) begin
          partial_point_next = {16'd0, text_byte[4:0]};
          bytes_due_next     = 2'd1;
        end else if (text_byte[7:4] == 4'b1110) begin
          partial_point_next = {17'd0, text_byte[3:0]};
          bytes_due_next     = 2'd2;
        end else if (text_byte[7:3] == 5'b11110) begin
          partial_point_next = {18'd0, text_byte[2:0]};
          bytes_due_next     = 2'd3;
        end else begin
          failed_next        = 1'b1;
          partial_point_next = '0;
          bytes_due_next     = '0;
        end
      end else if (text_byte[7:6] != 2'b10) begin
        failed_next        = 1'b1;
        partial_point_next = '0;
        bytes_due_next     = '0;
      end else begin
        bytes_due_next = bytes_due - 2'd1;
        if (bytes_due == 2'd1) begin
          cp                 = cont_point;
          finish             = 1'b1;
          partial_point_next = '0;
        end else begin
          partial_point_next = cont_point;
        end
      end

      if (finish) begin
        if (cp > u8u16_pkg::MAX_POINT ||
            (cp >= u8u16_pkg::SURR_FIRST && cp <= u8u16_pkg::SURR_LAST)) begin
          failed_next        = 1'b1;
          partial_point_next = '0;
          bytes_due_next     = '0;
        end else if (cp <= u8u16_pkg::BMP_LAST) begin
          if ({1'b0, units_emitted} + 17'd1 > {1'b0, capacity}) begin
            failed_next        = 1'b1;
            partial_point_next = '0;
            bytes_due_next     = '0;
          end else begin
            units_emitted_next   = units_emitted + 16'd1;
            dec.push_first       = 1'b1;
            dec.first.code_unit  = cp[15:0];
            dec.first.last       = 1'b1;
          end
        end else if ({1'b0, units_emitted} + 17'd2 > {1'b0, capacity}) begin
          failed_next        = 1'b1;
          partial_point_next = '0;
          bytes_due_next     = '0;
        end else begin
          units_emitted_next   = units_emitted + 16'd2;
          dec.push_first       = 1'b1;
          dec.push_second      = 1'b1;
          dec.first.code_unit  = u8u16_pkg::HIGH_SURR_BASE | {6'd0, supp_offset[19:10]};
          dec.second.code_unit = u8u16_pkg::LOW_SURR_BASE | {6'd0, supp_offset[9:0]};
          dec.second.last      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point <= '0;
      bytes_due     <= '0;
      units_emitted <= '0;
      failed        <= 1'b0;
    end else if (accept) begin
      partial_point <= partial_point_next;
      bytes_due     <= bytes_due_next;
      units_emitted <= units_emitted_next;
      failed        <= failed_next;
    end
  end

endmodule

// ===== sv/u8u16_result_fifo.sv =====
// ----------------------------------------------------------------------------
// u8u16_result_fifo
// Small result queue that takes up to two results per cycle and hands out
// one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module u8u16_result_fifo #(
  parameter int unsigned DEPTH = u8u16_pkg::RESULT_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  u8u16_pkg::dec_out_t dec,
  output logic                space_for_two,
  output logic                out_valid,
  input  logic                out_ready,
  output u8u16_pkg::result_t  out_result
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  u8u16_pkg::result_t mem [DEPTH];

  logic [PW-1:0] head, tail, tail_plus1, head_plus1;
  logic [CW-1:0] count, count_next;
  logic          push0, push1, pop;

  assign tail_plus1    = (tail == LAST_SLOT) ? '0 : tail + PW'(1);
  assign head_plus1    = (head == LAST_SLOT) ? '0 : head + PW'(1);
  assign push0         = accept && dec.push_first;
  assign push1         = accept && dec.push_second;
  assign pop           = out_valid && out_ready;
  assign space_for_two = (count <= CW'(DEPTH - 2));
  assign out_valid     = (count != '0);
  assign out_result    = mem[head];

  always_comb begin
    count_next = count + CW'(push0) + CW'(push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[tail] <= dec.first;
    end
    if (push1) begin
      mem[tail_plus1] <= dec.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head_plus1;
      end
      if (push1) begin
        tail <= (tail_plus1 == LAST_SLOT) ? '0 : tail_plus1 + PW'(1);
      end else if (push0) begin
        tail <= tail_plus1;
      end
    end
  end

endmodule

// ===== sv/utf8_to_utf16_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Streams UTF-8 bytes in and UTF-16 code units plus an end-of-string report out.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -----------------------------------------
//  input    in_valid / in_ready    kind, text_byte
//  output   out_valid / out_ready  result_kind, code_unit, status,
//                                  unit_count, last
//  config   cfg_valid / cfg_ready  out_capacity
//
// Each input transfer is decoded combinationally: the decoder state and the
// result queue update at the edge where the transfer is taken, and its first
// result can leave on the next cycle. The input side accepts one transfer per
// cycle while the result queue has room for two results, so the sustained rate
// is one byte per cycle while the output side drains one result per cycle (a
// surrogate pair is two results). Reset is synchronous and clears the decoder
// state, the queue pointers and restores the capacity to 65535. Output stalls
// back up through the queue into in_ready; the config port is always ready.
//
module utf8_to_utf16_transcoder_core #(
  parameter int unsigned RESULT_FIFO_DEPTH = u8u16_pkg::RESULT_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  text_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [15:0] code_unit,
  output logic        status,
  output logic [15:0] unit_count,
  output logic        last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] out_capacity
);

  logic [15:0]         capacity;
  logic                in_accept;
  logic                space_for_two;
  u8u16_pkg::dec_out_t dec;
  u8u16_pkg::result_t  out_result;

  // Room for a whole surrogate pair is required before a byte is taken, so a
  // transfer never has to be split across cycles.
  assign in_ready  = space_for_two;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= u8u16_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= out_capacity;
    end
  end

  u8u16_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .kind      (kind),
    .text_byte (text_byte),
    .capacity  (capacity),
    .dec       (dec)
  );

  u8u16_result_fifo #(
    .DEPTH (RESULT_FIFO_DEPTH)
  ) u_result_fifo (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .dec           (dec),
    .space_for_two (space_for_two),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result    (out_result)
  );

  assign result_kind = out_result.result_kind;
  assign code_unit   = out_result.code_unit;
  assign status      = out_result.status;
  assign unit_count  = out_result.unit_count;
  assign last        = out_result.last;

endmodule
